/* hdl/gqps_pkg.sv */
// gqps_pkg: types, constants and the glyph table for the glyph quad stream
// used by every file of the block; depends on nothing
`default_nettype none

package gqps_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam int COORD_W     = 16;
    localparam int COLOR_W     = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int WORD_W      = 32;
    localparam int TX_W        = 7;
    localparam int TY_W        = 4;

    localparam int CELL        = 7;
    localparam int CELLS_ROW   = 13;
    localparam int SHEET_X     = 4000;
    localparam int SHEET_Y     = 364;
    localparam int CLUT_X      = 1008;

    localparam logic [WORD_W-1:0] WORD_HEAD  = 32'h0900_0000;
    localparam logic [7:0]        COLOR_CODE = 8'h2C;
    localparam logic [5:0]        CLUT_LOW   = 6'(CLUT_X / 16);

    localparam logic [8:0] ROW_STROKE_UP  = 9'd399;
    localparam logic [8:0] ROW_FILL_UP    = 9'd398;
    localparam logic [8:0] ROW_STROKE_LOW = 9'd397;
    localparam logic [8:0] ROW_FILL_LOW   = 9'd396;
    localparam logic [8:0] ROW_SERIF      = 9'd395;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_BANG    = 8'h21;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_DASH    = 8'h2D;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_QUEST   = 8'h3F;
    localparam logic [7:0] CHAR_UP_A    = 8'h41;
    localparam logic [7:0] CHAR_UP_Z    = 8'h5A;
    localparam logic [7:0] CHAR_LOW_A   = 8'h61;
    localparam logic [7:0] CHAR_LOW_G   = 8'h67;
    localparam logic [7:0] CHAR_LOW_J   = 8'h6A;
    localparam logic [7:0] CHAR_LOW_P   = 8'h70;
    localparam logic [7:0] CHAR_LOW_Q   = 8'h71;
    localparam logic [7:0] CHAR_LOW_Y   = 8'h79;
    localparam logic [7:0] CHAR_LOW_Z   = 8'h7A;

    // word slots inside one quad
    localparam logic [3:0] W_HEAD   = 4'd0;
    localparam logic [3:0] W_COLOR  = 4'd1;
    localparam logic [3:0] W_XY00   = 4'd2;
    localparam logic [3:0] W_CLUT   = 4'd3;
    localparam logic [3:0] W_XY10   = 4'd4;
    localparam logic [3:0] W_TPAGE  = 4'd5;
    localparam logic [3:0] W_XY01   = 4'd6;
    localparam logic [3:0] W_UV01   = 4'd7;
    localparam logic [3:0] W_XY11   = 4'd8;
    localparam logic [3:0] W_UV11   = 4'd9;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ORIGIN_X      = 3'd0,
        CFG_ORIGIN_Y      = 3'd1,
        CFG_SERIF_SEL     = 3'd2,
        CFG_FILL_COLOR    = 3'd3,
        CFG_OUTLINE_COLOR = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic                      serif_sel;
        logic [COLOR_W-1:0]        fill_color;
        logic [COLOR_W-1:0]        outline_color;
    } cfg_t;

    // one placed glyph waiting for the back end
    typedef struct packed {
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [TX_W-1:0]    tx;
        logic [TY_W-1:0]    ty;
        logic               serif;
        logic               lower;
    } desc_t;

    typedef struct packed {
        logic            ok;
        logic [TX_W-1:0] tx;
        logic [TY_W-1:0] ty;
        logic            lower;
        logic            descend;
    } glyph_t;

    function automatic glyph_t glyph_lookup(input logic [7:0] c);
        glyph_t     g;
        logic [7:0] n;
        logic [3:0] cell_col;
        g        = '0;
        n        = '0;
        cell_col = '0;
        if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            n = c - CHAR_UP_A;
        end else if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) begin
            n = c - CHAR_LOW_A;
            g.lower = 1'b1;
            g.descend = (c == CHAR_LOW_G) || (c == CHAR_LOW_J) || (c == CHAR_LOW_P)
                     || (c == CHAR_LOW_Q) || (c == CHAR_LOW_Y);
        end
        priority if ((c >= CHAR_UP_A && c <= CHAR_UP_Z) || (c >= CHAR_LOW_A && c <= CHAR_LOW_Z))
        begin
            g.ok = 1'b1;
            cell_col = (n[4:0] >= 5'(CELLS_ROW)) ? 4'(n[4:0] - 5'(CELLS_ROW)) : n[3:0];
            g.tx = {3'b000, cell_col} * 7'(CELL);
            g.ty = (n[4:0] >= 5'(CELLS_ROW)) ? 4'(CELL) : 4'd0;
        end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            n    = c - CHAR_ZERO;
            g.ok = 1'b1;
            g.tx = {3'b000, n[3:0]} * 7'(CELL);
            g.ty = 4'(2 * CELL);
        end else begin
            g.ok = 1'b1;
            unique case (c)
                CHAR_BANG:    begin g.tx = 7'(13 * CELL); g.ty = 4'd0;          end
                CHAR_COLON:   begin g.tx = 7'(13 * CELL); g.ty = 4'(CELL);      end
                CHAR_QUEST:   begin g.tx = 7'(10 * CELL); g.ty = 4'(2 * CELL);  end
                CHAR_DASH:    begin g.tx = 7'(11 * CELL); g.ty = 4'(2 * CELL);  end
                CHAR_PERCENT: begin g.tx = 7'(12 * CELL); g.ty = 4'(2 * CELL);  end
                CHAR_DOT:     begin g.tx = 7'(13 * CELL); g.ty = 4'(2 * CELL);  end
                default:      g.ok = 1'b0;
            endcase
        end
        return g;
    endfunction

endpackage

`default_nettype wire

/* hdl/gqps_ifs.sv */
// gqps_ifs: valid/ready channel interfaces of the glyph quad stream
// character items in, primitive words out, register writes; uses gqps_pkg
`default_nettype none

interface gqps_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       new_string;
    modport source (output valid, character, new_string, input ready);
    modport sink (input valid, character, new_string, output ready);
endinterface

interface gqps_word_if;
    logic                            valid;
    logic                            ready;
    logic [gqps_pkg::WORD_W-1:0]     primitive_word;
    logic                            last_word;
    modport source (output valid, primitive_word, last_word, input ready);
    modport sink (input valid, primitive_word, last_word, output ready);
endinterface

interface gqps_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [gqps_pkg::CFG_INDEX_W-1:0]  index;
    logic [gqps_pkg::CFG_DATA_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hdl/gqps_front.sv */
// gqps_front: takes characters, keeps column and row, places glyphs
// uses gqps_pkg and gqps_item_if; feeds gqps_queue
`default_nettype none

module gqps_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    gqps_item_if.sink             item,
    input  wire gqps_pkg::cfg_t   cfg,
    input  wire logic             q_ready,
    output logic                  q_push,
    output gqps_pkg::desc_t       q_desc
);

    logic [gqps_pkg::COORD_W-1:0] col_reg, col_next;
    logic [gqps_pkg::COORD_W-1:0] row_reg, row_next;
    logic [gqps_pkg::COORD_W-1:0] col_base, row_base, col_step;
    gqps_pkg::glyph_t             glyph;
    logic                         accept, is_nl, lower, drop;

    assign item.ready = q_ready;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        glyph    = gqps_pkg::glyph_lookup(item.character);
        col_base = item.new_string ? '0 : col_reg;
        row_base = item.new_string ? '0 : row_reg;
        is_nl    = (item.character == gqps_pkg::CHAR_NEWLINE);
        // pitch 8 is a shift, pitch 7 is the shift minus the column
        col_step = cfg.serif_sel ? {col_base[12:0], 3'b000}
                                 : ({col_base[12:0], 3'b000} - col_base);
        lower    = glyph.lower && !cfg.serif_sel;
        drop     = lower && glyph.descend;
        if (is_nl)
        begin
            row_next = row_base + 16'(gqps_pkg::CELL);
            col_next = '0;
        end
        else
        begin
            row_next = row_base;
            col_next = col_base + 16'd1;
        end
        q_desc.x0    = $unsigned(cfg.origin_x) + col_step;
        q_desc.y0    = $unsigned(cfg.origin_y) + row_base + {15'b0, drop};
        q_desc.tx    = glyph.tx;
        q_desc.ty    = glyph.ty;
        q_desc.serif = cfg.serif_sel;
        q_desc.lower = lower;
        q_push       = accept && glyph.ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/gqps_queue.sv */
// gqps_queue: short first-in first-out queue of placed glyphs
// between gqps_front and gqps_back; uses gqps_pkg
`default_nettype none

module gqps_queue #(
    parameter int DEPTH = gqps_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire gqps_pkg::desc_t  push_desc,
    output logic                  ready,
    input  wire logic             pop,
    output logic                  valid,
    output gqps_pkg::desc_t       pop_desc
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gqps_pkg::desc_t  store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign ready    = (count_reg != CNT_W'(DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_desc = store_reg[rd_ptr_reg];
    assign do_push  = push && ready;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= push_desc;
    end

endmodule

`default_nettype wire

/* hdl/gqps_back.sv */
// gqps_back: walks each placed glyph through its quad words, one a cycle while result is ready
// uses gqps_pkg and gqps_word_if; fed by gqps_queue
`default_nettype none

module gqps_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire gqps_pkg::cfg_t   cfg,
    input  wire logic             q_valid,
    input  wire gqps_pkg::desc_t  q_desc,
    output logic                  q_pop,
    gqps_word_if.source           result
);

    gqps_pkg::desc_t              cur_reg;
    logic                         cur_vld_reg, cur_vld_next;
    logic                         quad_reg, quad_next;
    logic [3:0]                   slot_reg, slot_next;
    logic                         out_valid_reg;
    logic [gqps_pkg::WORD_W-1:0]  out_word_reg;
    logic                         out_last_reg;

    logic                         advance, emit, is_last;
    logic [8:0]                   pal_row;
    logic [gqps_pkg::COLOR_W-1:0] color;
    logic [15:0]                  clut, tpage, x1, y1;
    logic [11:0]                  sx;
    logic [8:0]                   sy, u1_sum, v1_sum;
    logic [7:0]                   u0, v0, u1, v1;
    logic [gqps_pkg::WORD_W-1:0]  word;

    assign result.valid          = out_valid_reg;
    assign result.primitive_word = out_word_reg;
    assign result.last_word      = out_last_reg;

    assign advance = !out_valid_reg || result.ready;
    assign emit    = advance && cur_vld_reg;
    assign is_last = (slot_reg == gqps_pkg::W_UV11) && (cur_reg.serif || quad_reg);
    assign q_pop   = q_valid && (!cur_vld_reg || (emit && is_last));

    always_comb
    begin
        // first quad of the stroke font is the outline pass
        if (cur_reg.serif)
            pal_row = gqps_pkg::ROW_SERIF;
        else if (cur_reg.lower)
            pal_row = quad_reg ? gqps_pkg::ROW_FILL_LOW : gqps_pkg::ROW_STROKE_LOW;
        else
            pal_row = quad_reg ? gqps_pkg::ROW_FILL_UP : gqps_pkg::ROW_STROKE_UP;
        color  = (cur_reg.serif || quad_reg) ? cfg.fill_color : cfg.outline_color;
        clut   = {1'b0, pal_row, gqps_pkg::CLUT_LOW};
        sx     = 12'(gqps_pkg::SHEET_X) + {5'b0, cur_reg.tx};
        sy     = 9'(gqps_pkg::SHEET_Y) + {5'b0, cur_reg.ty};
        tpage  = {11'b0, sy[8], sx[11:8]};
        u0     = sx[7:0];
        v0     = sy[7:0];
        u1_sum = {1'b0, u0} + 9'(gqps_pkg::CELL);
        v1_sum = {1'b0, v0} + 9'(gqps_pkg::CELL);
        u1     = u1_sum[8] ? 8'hFF : u1_sum[7:0];
        v1     = v1_sum[8] ? 8'hFF : v1_sum[7:0];
        x1     = cur_reg.x0 + 16'(gqps_pkg::CELL);
        y1     = cur_reg.y0 + 16'(gqps_pkg::CELL);
        unique case (slot_reg)
            gqps_pkg::W_HEAD:  word = gqps_pkg::WORD_HEAD;
            gqps_pkg::W_COLOR: word = {gqps_pkg::COLOR_CODE, color};
            gqps_pkg::W_XY00:  word = {cur_reg.y0, cur_reg.x0};
            gqps_pkg::W_CLUT:  word = {clut, v0, u0};
            gqps_pkg::W_XY10:  word = {cur_reg.y0, x1};
            gqps_pkg::W_TPAGE: word = {tpage, v0, u1};
            gqps_pkg::W_XY01:  word = {y1, cur_reg.x0};
            gqps_pkg::W_UV01:  word = {16'b0, v1, u0};
            gqps_pkg::W_XY11:  word = {y1, x1};
            gqps_pkg::W_UV11:  word = {16'b0, v1, u1};
            default:           word = '0;
        endcase

        cur_vld_next = cur_vld_reg;
        quad_next    = quad_reg;
        slot_next    = slot_reg;
        if (emit)
        begin
            if (slot_reg == gqps_pkg::W_UV11)
            begin
                slot_next = gqps_pkg::W_HEAD;
                quad_next = !quad_reg && !cur_reg.serif;
                if (is_last)
                    cur_vld_next = 1'b0;
            end
            else
            begin
                slot_next = slot_reg + 4'd1;
            end
        end
        if (q_pop)
        begin
            cur_vld_next = 1'b1;
            quad_next    = 1'b0;
            slot_next    = gqps_pkg::W_HEAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_vld_reg   <= 1'b0;
            quad_reg      <= 1'b0;
            slot_reg      <= gqps_pkg::W_HEAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_vld_reg <= cur_vld_next;
            quad_reg    <= quad_next;
            slot_reg    <= slot_next;
            if (advance)
                out_valid_reg <= cur_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_desc;
        if (emit)
        begin
            out_word_reg <= word;
            out_last_reg <= is_last;
        end
    end

endmodule

`default_nettype wire

/* hdl/glyph_quad_primitive_stream.sv */
// glyph_quad_primitive_stream: top level, register file, front, queue and back
// uses gqps_pkg, gqps_ifs, gqps_front, gqps_queue, gqps_back
`default_nettype none

// Text renderer: one character per transfer on item, ten-word textured-quad
// primitives on result. The front takes a character every cycle while the
// glyph queue (QUEUE_DEPTH entries) has room; space, newline and unsupported
// characters are taken the same way and produce nothing. The back sends one
// word per cycle on result while result is ready; a stroke-font glyph is two
// quads (outline, then fill), a serif glyph one; that output rate sets throughput.
// Register writes on cfg are taken every cycle and must only be issued while
// the block holds no glyph in flight.
module glyph_quad_primitive_stream #(
    parameter int QUEUE_DEPTH = gqps_pkg::QUEUE_DEPTH
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    gqps_item_if.sink   item,
    gqps_word_if.source result,
    gqps_cfg_if.sink    cfg
);

    gqps_pkg::cfg_t   cfg_reg;
    gqps_pkg::desc_t  push_desc, pop_desc;
    logic             q_push, q_ready, q_pop, q_valid;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x      <= '0;
            cfg_reg.origin_y      <= '0;
            cfg_reg.serif_sel     <= 1'b0;
            cfg_reg.fill_color    <= 24'h808080;
            cfg_reg.outline_color <= 24'h010101;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (gqps_pkg::cfg_index_t'(cfg.index))
                gqps_pkg::CFG_ORIGIN_X:      cfg_reg.origin_x      <= cfg.data[15:0];
                gqps_pkg::CFG_ORIGIN_Y:      cfg_reg.origin_y      <= cfg.data[15:0];
                gqps_pkg::CFG_SERIF_SEL:     cfg_reg.serif_sel     <= cfg.data[0];
                gqps_pkg::CFG_FILL_COLOR:    cfg_reg.fill_color    <= cfg.data[23:0];
                gqps_pkg::CFG_OUTLINE_COLOR: cfg_reg.outline_color <= cfg.data[23:0];
                default: ;
            endcase
        end
    end

    gqps_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .cfg     (cfg_reg),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_desc  (push_desc)
    );

    gqps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (push_desc),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_desc  (pop_desc)
    );

    gqps_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_desc  (pop_desc),
        .q_pop   (q_pop),
        .result  (result)
    );

    // newline and space never reach the queue
    a_no_push_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && (item.character == gqps_pkg::CHAR_NEWLINE
            || item.character == gqps_pkg::CHAR_SPACE)) |-> !q_push)
        else $error("blank character pushed a glyph");

    a_push_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (item.valid && item.ready && q_ready))
        else $error("glyph pushed without an item transfer");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("glyph popped from an empty queue");

endmodule

`default_nettype wire

/* sim/testbench.sv */
// testbench for glyph_quad_primitive_stream: directed table and random text
// needs gqps_pkg, the channel interfaces in gqps_ifs and the block's rtl
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 82;

    typedef struct packed {
        logic [gqps_pkg::WORD_W-1:0] word;
        logic                        last;
    } word_exp_t;

    typedef struct {
        bit                   is_cfg;
        gqps_pkg::cfg_index_t idx;
        logic [23:0]          data;
        logic [7:0]           ch;
        logic                 ns;
        bit                   chk;
        int                   n;
        logic [31:0]          xy;
    } plan_row_t;

    logic clk;
    logic rst_n;

    gqps_item_if item_ch ();
    gqps_word_if word_ch ();
    gqps_cfg_if  cfg_ch ();

    glyph_quad_primitive_stream dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (word_ch),
        .cfg    (cfg_ch)
    );

    // predictor copy of registers and text position
    logic [15:0] cfg_ox;
    logic [15:0] cfg_oy;
    logic        cfg_serif;
    logic [23:0] cfg_fill;
    logic [23:0] cfg_outline;
    logic [15:0] col_idx;
    logic [15:0] row_off;

    word_exp_t   word_q[$];
    plan_row_t   plan[$];

    int          src_idle;
    int          sink_idle;
    int          errors;
    int          n_chars;
    int          n_words;
    int          n_writes;
    int          quiet_cycles;

    // typed expectation for the table row now on the item channel
    bit          tab_chk;
    int          tab_n;
    logic [31:0] tab_xy;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic bit glyph_cell(input logic [7:0] ch, output int gx, output int gy);
        int n;
        gx = 0;
        gy = 0;
        if (ch >= gqps_pkg::CHAR_UP_A && ch <= gqps_pkg::CHAR_UP_Z) begin
            n  = ch - gqps_pkg::CHAR_UP_A;
            gx = (n % gqps_pkg::CELLS_ROW) * gqps_pkg::CELL;
            gy = (n / gqps_pkg::CELLS_ROW) * gqps_pkg::CELL;
            return 1'b1;
        end
        if (ch >= gqps_pkg::CHAR_LOW_A && ch <= gqps_pkg::CHAR_LOW_Z) begin
            n  = ch - gqps_pkg::CHAR_LOW_A;
            gx = (n % gqps_pkg::CELLS_ROW) * gqps_pkg::CELL;
            gy = (n / gqps_pkg::CELLS_ROW) * gqps_pkg::CELL;
            return 1'b1;
        end
        if (ch >= gqps_pkg::CHAR_ZERO && ch <= gqps_pkg::CHAR_NINE) begin
            gx = (ch - gqps_pkg::CHAR_ZERO) * gqps_pkg::CELL;
            gy = 2 * gqps_pkg::CELL;
            return 1'b1;
        end
        case (ch)
            gqps_pkg::CHAR_BANG:    begin gx = 13 * gqps_pkg::CELL; gy = 0;                  end
            gqps_pkg::CHAR_COLON:   begin gx = 13 * gqps_pkg::CELL; gy = gqps_pkg::CELL;     end
            gqps_pkg::CHAR_QUEST:   begin gx = 10 * gqps_pkg::CELL; gy = 2 * gqps_pkg::CELL; end
            gqps_pkg::CHAR_DASH:    begin gx = 11 * gqps_pkg::CELL; gy = 2 * gqps_pkg::CELL; end
            gqps_pkg::CHAR_PERCENT: begin gx = 12 * gqps_pkg::CELL; gy = 2 * gqps_pkg::CELL; end
            gqps_pkg::CHAR_DOT:     begin gx = 13 * gqps_pkg::CELL; gy = 2 * gqps_pkg::CELL; end
            default:                return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic void push_quad(input logic [15:0] x0, input logic [15:0] y0,
                                      input int gx, input int gy, input logic [8:0] pal,
                                      input logic [23:0] color, input bit last);
        int          sx;
        int          sy;
        int          u0;
        int          v0;
        int          u1;
        int          v1;
        int          pal_i;
        logic [15:0] x1;
        logic [15:0] y1;
        logic [15:0] clut;
        logic [15:0] tpage;
        logic [31:0] w[10];
        sx    = gqps_pkg::SHEET_X + gx;
        sy    = gqps_pkg::SHEET_Y + gy;
        pal_i = pal;
        clut  = 16'((pal_i << 6) | (gqps_pkg::CLUT_X / 16));
        tpage = 16'(((sy / 256) << 4) | (sx / 256));
        u0    = sx % 256;
        v0    = sy % 256;
        // texture ends stop at the page edge
        u1    = (u0 + gqps_pkg::CELL > 255) ? 255 : u0 + gqps_pkg::CELL;
        v1    = (v0 + gqps_pkg::CELL > 255) ? 255 : v0 + gqps_pkg::CELL;
        x1    = x0 + 16'd7;
        y1    = y0 + 16'd7;
        w[0]  = gqps_pkg::WORD_HEAD;
        w[1]  = {gqps_pkg::COLOR_CODE, color};
        w[2]  = {y0, x0};
        w[3]  = {clut, 8'(v0), 8'(u0)};
        w[4]  = {y0, x1};
        w[5]  = {tpage, 8'(v0), 8'(u1)};
        w[6]  = {y1, x0};
        w[7]  = {16'h0000, 8'(v1), 8'(u0)};
        w[8]  = {y1, x1};
        w[9]  = {16'h0000, 8'(v1), 8'(u1)};
        for (int k = 0; k < 10; k++)
        begin
            word_q.push_back('{word: w[k], last: (last && k == 9)});
        end
    endfunction

    // advance the text position for one character and queue the words it draws
    function automatic void place_char(input logic [7:0] ch, input logic ns);
        int          gx;
        int          gy;
        int          n_out;
        bit          lower;
        bit          drop;
        logic [15:0] pitch;
        logic [15:0] x0;
        logic [15:0] y0;
        logic [31:0] first_xy;
        n_out    = 0;
        first_xy = '0;
        if (ns) begin
            col_idx = '0;
            row_off = '0;
        end
        if (ch == gqps_pkg::CHAR_NEWLINE) begin
            row_off = row_off + 16'd7;
            col_idx = '0;
        end else begin
            if (ch != gqps_pkg::CHAR_SPACE && glyph_cell(ch, gx, gy)) begin
                lower = (ch >= gqps_pkg::CHAR_LOW_A && ch <= gqps_pkg::CHAR_LOW_Z)
                        && !cfg_serif;
                drop  = lower && (ch == gqps_pkg::CHAR_LOW_G || ch == gqps_pkg::CHAR_LOW_J
                               || ch == gqps_pkg::CHAR_LOW_P || ch == gqps_pkg::CHAR_LOW_Q
                               || ch == gqps_pkg::CHAR_LOW_Y);
                pitch = cfg_serif ? 16'd8 : 16'd7;
                x0    = cfg_ox + col_idx * pitch;
                y0    = cfg_oy + row_off + (drop ? 16'd1 : 16'd0);
                first_xy = {y0, x0};
                if (cfg_serif) begin
                    push_quad(x0, y0, gx, gy, gqps_pkg::ROW_SERIF, cfg_fill, 1'b1);
                    n_out = 10;
                end else begin
                    push_quad(x0, y0, gx, gy,
                              lower ? gqps_pkg::ROW_STROKE_LOW : gqps_pkg::ROW_STROKE_UP,
                              cfg_outline, 1'b0);
                    push_quad(x0, y0, gx, gy,
                              lower ? gqps_pkg::ROW_FILL_LOW : gqps_pkg::ROW_FILL_UP,
                              cfg_fill, 1'b1);
                    n_out = 20;
                end
            end
            col_idx = col_idx + 16'd1;
        end
        if (tab_chk) begin
            if (n_out != tab_n || (n_out != 0 && first_xy !== tab_xy)) begin
                $display("%0t: char %h expected %0d words at xy %h, actual %0d at %h",
                         $time, ch, tab_n, tab_xy, n_out, first_xy);
                errors++;
            end
        end
    endfunction

    // transfers seen on every channel, checking and watchdog
    always @(posedge clk)
    begin
        word_exp_t exp_w;
        if (rst_n) begin
            quiet_cycles = quiet_cycles + 1;
            if (cfg_ch.valid && cfg_ch.ready) begin
                quiet_cycles = 0;
                n_writes++;
                case (gqps_pkg::cfg_index_t'(cfg_ch.index))
                    gqps_pkg::CFG_ORIGIN_X:      cfg_ox      = cfg_ch.data[15:0];
                    gqps_pkg::CFG_ORIGIN_Y:      cfg_oy      = cfg_ch.data[15:0];
                    gqps_pkg::CFG_SERIF_SEL:     cfg_serif   = cfg_ch.data[0];
                    gqps_pkg::CFG_FILL_COLOR:    cfg_fill    = cfg_ch.data[23:0];
                    gqps_pkg::CFG_OUTLINE_COLOR: cfg_outline = cfg_ch.data[23:0];
                    default: ;
                endcase
            end
            if (item_ch.valid && item_ch.ready) begin
                quiet_cycles = 0;
                n_chars++;
                place_char(item_ch.character, item_ch.new_string);
            end
            if (word_ch.valid && word_ch.ready) begin
                quiet_cycles = 0;
                n_words++;
                if (word_q.size() == 0) begin
                    $display("%0t: word expected none, actual %h last %b",
                             $time, word_ch.primitive_word, word_ch.last_word);
                    errors++;
                end else begin
                    exp_w = word_q.pop_front();
                    if (word_ch.primitive_word !== exp_w.word) begin
                        $display("%0t: primitive_word expected %h, actual %h",
                                 $time, exp_w.word, word_ch.primitive_word);
                        errors++;
                    end
                    if (word_ch.last_word !== exp_w.last) begin
                        $display("%0t: last_word expected %b, actual %b",
                                 $time, exp_w.last, word_ch.last_word);
                        errors++;
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog, no transfer for %0d cycles, %0d words pending",
                         $time, quiet_cycles, word_q.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        word_ch.ready <= ($urandom_range(99) >= sink_idle);
    end

    task automatic send_char(input logic [7:0] ch, input logic ns, input bit chk,
                             input int n, input logic [31:0] xy);
        @(negedge clk);
        while ($urandom_range(99) < src_idle)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        tab_chk = chk;
        tab_n   = n;
        tab_xy  = xy;
        item_ch.valid      <= 1'b1;
        item_ch.character  <= ch;
        item_ch.new_string <= ns;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    task automatic write_reg(input gqps_pkg::cfg_index_t idx, input logic [23:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // block idle: nothing pending and characters without output have passed through
    task automatic settle();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (word_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic void add_item(input logic [7:0] ch, input logic ns, input bit chk,
                                     input int n, input logic [31:0] xy);
        plan.push_back('{is_cfg: 1'b0, idx: gqps_pkg::CFG_ORIGIN_X, data: '0, ch: ch,
                         ns: ns, chk: chk, n: n, xy: xy});
    endfunction

    function automatic void add_cfg(input gqps_pkg::cfg_index_t idx, input logic [23:0] data);
        plan.push_back('{is_cfg: 1'b1, idx: idx, data: data, ch: '0, ns: 1'b0,
                         chk: 1'b0, n: 0, xy: '0});
    endfunction

    function automatic logic [7:0] pick_char();
        logic [7:0] b;
        int         gx;
        int         gy;
        int         r;
        r = $urandom_range(99);
        if (r < 20) return gqps_pkg::CHAR_UP_A + 8'($urandom_range(25));
        if (r < 40) return gqps_pkg::CHAR_LOW_A + 8'($urandom_range(25));
        if (r < 50) return gqps_pkg::CHAR_ZERO + 8'($urandom_range(9));
        if (r < 58) begin
            case ($urandom_range(5))
                0:       return gqps_pkg::CHAR_BANG;
                1:       return gqps_pkg::CHAR_COLON;
                2:       return gqps_pkg::CHAR_QUEST;
                3:       return gqps_pkg::CHAR_DASH;
                4:       return gqps_pkg::CHAR_PERCENT;
                default: return gqps_pkg::CHAR_DOT;
            endcase
        end
        if (r < 72) return gqps_pkg::CHAR_SPACE;
        if (r < 80) return gqps_pkg::CHAR_NEWLINE;
        // anything the font sheet does not hold
        do b = 8'($urandom_range(255));
        while (glyph_cell(b, gx, gy) || b == gqps_pkg::CHAR_SPACE
               || b == gqps_pkg::CHAR_NEWLINE);
        return b;
    endfunction

    initial
    begin
        logic font_bit;
        item_ch.valid      = 1'b0;
        item_ch.character  = '0;
        item_ch.new_string = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = '0;
        cfg_ch.data        = '0;
        word_ch.ready      = 1'b0;
        cfg_ox       = '0;
        cfg_oy       = '0;
        cfg_serif    = 1'b0;
        cfg_fill     = 24'h808080;
        cfg_outline  = 24'h010101;
        col_idx      = '0;
        row_off      = '0;
        errors       = 0;
        n_chars      = 0;
        n_words      = 0;
        n_writes     = 0;
        quiet_cycles = 0;
        tab_chk      = 1'b0;
        tab_n        = 0;
        tab_xy       = '0;
        src_idle     = 24;
        sink_idle    = 49;
        rst_n        = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults, every symbol, descender, unsupported bytes
        add_item(gqps_pkg::CHAR_UP_A, 1'b0, 1'b1, 20, 32'h0000_0000);
        add_item(gqps_pkg::CHAR_LOW_Z, 1'b0, 1'b1, 20, 32'h0000_0007);
        add_item(gqps_pkg::CHAR_SPACE, 1'b0, 1'b1, 0, '0);
        add_item(gqps_pkg::CHAR_LOW_G, 1'b0, 1'b1, 20, 32'h0001_0015);
        add_item(8'h00, 1'b0, 1'b1, 0, '0);
        add_item(8'hFF, 1'b0, 1'b1, 0, '0);
        add_item(gqps_pkg::CHAR_NEWLINE, 1'b0, 1'b1, 0, '0);
        add_item(gqps_pkg::CHAR_ZERO, 1'b0, 1'b1, 20, 32'h0007_0000);
        add_item(gqps_pkg::CHAR_NINE, 1'b0, 1'b0, 0, '0);
        add_item(gqps_pkg::CHAR_BANG, 1'b0, 1'b0, 0, '0);
        add_item(gqps_pkg::CHAR_COLON, 1'b0, 1'b0, 0, '0);
        add_item(gqps_pkg::CHAR_QUEST, 1'b0, 1'b0, 0, '0);
        add_item(gqps_pkg::CHAR_DASH, 1'b0, 1'b0, 0, '0);
        add_item(gqps_pkg::CHAR_PERCENT, 1'b0, 1'b0, 0, '0);
        add_item(gqps_pkg::CHAR_DOT, 1'b0, 1'b0, 0, '0);
        add_item(8'h7E, 1'b0, 1'b1, 0, '0);
        add_item(gqps_pkg::CHAR_UP_A + 8'd16, 1'b1, 1'b1, 20, 32'h0000_0000);
        // serif font at the top extremes
        add_cfg(gqps_pkg::CFG_ORIGIN_X, 24'h007FFF);
        add_cfg(gqps_pkg::CFG_ORIGIN_Y, 24'h007FFF);
        add_cfg(gqps_pkg::CFG_SERIF_SEL, 24'h000001);
        add_cfg(gqps_pkg::CFG_FILL_COLOR, 24'hFFFFFF);
        add_cfg(gqps_pkg::CFG_OUTLINE_COLOR, 24'hFFFFFF);
        add_item(gqps_pkg::CHAR_UP_A + 8'd12, 1'b1, 1'b1, 10, 32'h7FFF_7FFF);
        add_item(gqps_pkg::CHAR_LOW_Y, 1'b0, 1'b1, 10, 32'h7FFF_8007);
        add_item(gqps_pkg::CHAR_LOW_J, 1'b0, 1'b0, 0, '0);
        // stroke font at the bottom extremes
        add_cfg(gqps_pkg::CFG_ORIGIN_X, 24'h008000);
        add_cfg(gqps_pkg::CFG_ORIGIN_Y, 24'h008000);
        add_cfg(gqps_pkg::CFG_SERIF_SEL, 24'h000000);
        add_cfg(gqps_pkg::CFG_FILL_COLOR, 24'h000000);
        add_cfg(gqps_pkg::CFG_OUTLINE_COLOR, 24'h000000);
        add_item(gqps_pkg::CHAR_LOW_P, 1'b1, 1'b1, 20, 32'h8001_8000);
        add_item(gqps_pkg::CHAR_NEWLINE, 1'b0, 1'b1, 0, '0);
        add_item(gqps_pkg::CHAR_LOW_Q, 1'b0, 1'b1, 20, 32'h8008_8000);
        add_item(gqps_pkg::CHAR_UP_Z, 1'b0, 1'b0, 0, '0);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg) begin
                settle();
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                send_char(plan[i].ch, plan[i].ns, plan[i].chk, plan[i].n, plan[i].xy);
            end
        end

        // random text under three idle mixes, fresh registers for each
        for (int p = 0; p < 3; p++)
        begin
            settle();
            src_idle  = (p == 0) ? 24 : (p == 1) ? 49 : 0;
            sink_idle = (p == 0) ? 49 : (p == 1) ? 24 : 0;
            font_bit  = (p == 2) ? 1'($urandom_range(1)) : 1'(p);
            write_reg(gqps_pkg::CFG_ORIGIN_X, 24'($urandom));
            write_reg(gqps_pkg::CFG_ORIGIN_Y, 24'($urandom));
            write_reg(gqps_pkg::CFG_SERIF_SEL, {23'($urandom), font_bit});
            write_reg(gqps_pkg::CFG_FILL_COLOR, 24'($urandom));
            write_reg(gqps_pkg::CFG_OUTLINE_COLOR, 24'($urandom));
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                send_char(pick_char(), ($urandom_range(99) < 6), 1'b0, 0, '0);
            end
        end

        settle();

        $display("covered %0d characters and %0d primitive words with %0d register writes,",
                 n_chars, n_words, n_writes);
        $display("both fonts, origin extremes, unsupported bytes, three idle mixes; %0d errors",
                 errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
hdl/gqps_pkg.sv
hdl/gqps_ifs.sv
hdl/gqps_front.sv
hdl/gqps_queue.sv
hdl/gqps_back.sv
hdl/glyph_quad_primitive_stream.sv
sim/testbench.sv
